FILE: src/qrs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Quadratic root solver package
// Widths, codes, pipeline stage types and the shared division step.
// ----------------------------------------------------------------------------
package qrs_pkg;

  localparam int COEF_BITS  = 16;
  localparam int FRAC_BITS  = 16;
  localparam int ROOT_BITS  = 48;
  localparam int SQRT_PAIRS = 26;

  localparam int SQRT_STEPS = SQRT_PAIRS + FRAC_BITS;
  localparam int RAD_W      = 2 * SQRT_STEPS;
  localparam int ROOT_W     = SQRT_STEPS;
  localparam int REM_W      = ROOT_W + 3;
  localparam int PROD_W     = 2 * COEF_BITS;
  localparam int D_W        = 2 * COEF_BITS + 3;
  localparam int BASE_W     = COEF_BITS + FRAC_BITS + 1;
  localparam int DEN_S      = COEF_BITS + 2;
  localparam int DMAG_W     = COEF_BITS + 1;
  localparam int DREM_W     = DMAG_W + 1;
  localparam int NUM_S      = ROOT_W + 2;
  localparam int NUM_W      = ROOT_W + 1;

  localparam logic [1:0] CNT_NONE = 2'd0;
  localparam logic [1:0] CNT_ONE  = 2'd1;
  localparam logic [1:0] CNT_TWO  = 2'd2;
  localparam logic [1:0] CNT_ALL  = 2'd3;

  typedef enum logic [2:0] {
    KIND_NONE,
    KIND_ALL,
    KIND_LIN,
    KIND_DBL,
    KIND_TWO
  } kind_t;

  typedef struct packed {
    logic                     valid;
    kind_t                    kind;
    logic signed [BASE_W-1:0] base;
    logic signed [DEN_S-1:0]  den;
    logic [RAD_W-1:0]         rad;
    logic [REM_W-1:0]         rem;
    logic [ROOT_W-1:0]        root;
  } sq_stage_t;

  typedef struct packed {
    logic [NUM_W-1:0]  num;
    logic [DREM_W-1:0] rem;
    logic [NUM_W-1:0]  q;
  } dv_lane_t;

  typedef struct packed {
    logic              valid;
    kind_t             kind;
    logic              neg1;
    logic              neg2;
    logic [DMAG_W-1:0] dmag;
    dv_lane_t          l1;
    dv_lane_t          l2;
  } dv_stage_t;

  function automatic dv_lane_t div_step(dv_lane_t cur, logic [DMAG_W-1:0] dmag);
    dv_lane_t          nxt;
    logic [DREM_W-1:0] rsh;
    logic              ge;
    rsh = {cur.rem[DREM_W-2:0], cur.num[NUM_W-1]};
    ge = rsh >= DREM_W'(dmag);
    nxt.rem = ge ? rsh - DREM_W'(dmag) : rsh;
    nxt.num = cur.num << 1;
    nxt.q = {cur.q[NUM_W-2:0], ge};
    return nxt;
  endfunction

endpackage

FILE: src/qrs_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Coefficient channel
// Valid/ready channel carrying one set of coefficients per word.
// ----------------------------------------------------------------------------
interface qrs_in_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [qrs_pkg::COEF_BITS-1:0] coef_a;
  logic signed [qrs_pkg::COEF_BITS-1:0] coef_b;
  logic signed [qrs_pkg::COEF_BITS-1:0] coef_c;

  modport source (output valid, coef_a, coef_b, coef_c, input ready);
  modport sink (input valid, coef_a, coef_b, coef_c, output ready);
endinterface

FILE: src/qrs_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Root channel
// Valid/ready channel carrying the root count and two roots per word.
// ----------------------------------------------------------------------------
interface qrs_out_if;
  logic                                 valid;
  logic                                 ready;
  logic [1:0]                           root_count;
  logic signed [qrs_pkg::ROOT_BITS-1:0] first_root;
  logic signed [qrs_pkg::ROOT_BITS-1:0] second_root;

  modport source (output valid, root_count, first_root, second_root, input ready);
  modport sink (input valid, root_count, first_root, second_root, output ready);
endinterface

FILE: src/qrs_sqrt_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Square root cell
// One digit-by-digit square root step with its registered stage.
// ----------------------------------------------------------------------------
module qrs_sqrt_cell (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  qrs_pkg::sq_stage_t prev,
  output qrs_pkg::sq_stage_t stage
);
  import qrs_pkg::*;

  sq_stage_t        stage_next;
  logic [REM_W-1:0] rsh;
  logic [REM_W-1:0] trial;
  logic             ge;

  always_comb begin
    rsh = {prev.rem[REM_W-3:0], prev.rad[RAD_W-1 -: 2]};
    trial = REM_W'({prev.root, 2'b01});
    ge = rsh >= trial;
    stage_next = prev;
    stage_next.rad = prev.rad << 2;
    stage_next.rem = ge ? rsh - trial : rsh;
    stage_next.root = {prev.root[ROOT_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage.valid <= 1'b0;
    end else if (en) begin
      stage <= stage_next;
    end
  end
endmodule

FILE: src/qrs_div_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Division cell
// One restoring division step for both root numerators with its stage.
// ----------------------------------------------------------------------------
module qrs_div_cell (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  qrs_pkg::dv_stage_t prev,
  output qrs_pkg::dv_stage_t stage
);
  import qrs_pkg::*;

  dv_stage_t stage_next;

  always_comb begin
    stage_next = prev;
    stage_next.l1 = div_step(prev.l1, prev.dmag);
    stage_next.l2 = div_step(prev.l2, prev.dmag);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage.valid <= 1'b0;
    end else if (en) begin
      stage <= stage_next;
    end
  end
endmodule

FILE: src/quadratic_root_solver.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Quadratic root solver
// Pipeline registers: input, multiply, discriminant, 42 square root cells,
// numerator setup, 43 division cells and the output register.
// Throughput is one word per cycle; the whole chain halts while a result waits.
// Reset clears all valid bits; no item is in flight after reset.
// ----------------------------------------------------------------------------
module quadratic_root_solver (
  input logic     clk,
  input logic     rst,
  qrs_in_if.sink  coefs,
  qrs_out_if.source roots
);
  import qrs_pkg::*;

  typedef struct packed {
    logic                        valid;
    logic signed [COEF_BITS-1:0] a;
    logic signed [COEF_BITS-1:0] b;
    logic signed [COEF_BITS-1:0] c;
  } in_stage_t;

  typedef struct packed {
    logic                        valid;
    logic signed [COEF_BITS-1:0] a;
    logic signed [COEF_BITS-1:0] b;
    logic signed [COEF_BITS-1:0] c;
    logic signed [PROD_W-1:0]    bb;
    logic signed [PROD_W-1:0]    ac;
  } mul_stage_t;

  logic       en;
  in_stage_t  s1;
  mul_stage_t s2;
  sq_stage_t  s3_next;
  sq_stage_t  sq [SQRT_STEPS+1];
  dv_stage_t  dv_next;
  dv_stage_t  dv [NUM_W+1];

  logic signed [D_W-1:0]    d;
  logic signed [NUM_S-1:0]  bx, sx, n1, n2, m1, m2;
  logic signed [DEN_S-1:0]  dabs;
  logic [ROOT_BITS-1:0]     q1, q2;

  assign en = !roots.valid || roots.ready;
  assign coefs.ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1.valid <= 1'b0;
      s2.valid <= 1'b0;
      sq[0].valid <= 1'b0;
    end else if (en) begin
      s1.valid <= coefs.valid;
      s1.a <= coefs.coef_a;
      s1.b <= coefs.coef_b;
      s1.c <= coefs.coef_c;
      s2.valid <= s1.valid;
      s2.a <= s1.a;
      s2.b <= s1.b;
      s2.c <= s1.c;
      s2.bb <= s1.b * s1.b;
      s2.ac <= s1.a * s1.c;
      sq[0] <= s3_next;
    end
  end

  always_comb begin
    d = D_W'(s2.bb) - (D_W'(s2.ac) <<< 2);
    s3_next.valid = s2.valid;
    if (s2.a == '0) begin
      if (s2.b == '0) begin
        s3_next.kind = (s2.c == '0) ? KIND_ALL : KIND_NONE;
      end else begin
        s3_next.kind = KIND_LIN;
      end
    end else if (d < 0) begin
      s3_next.kind = KIND_NONE;
    end else if (d == '0) begin
      s3_next.kind = KIND_DBL;
    end else begin
      s3_next.kind = KIND_TWO;
    end
    if (s2.a == '0) begin
      s3_next.base = (-BASE_W'(s2.c)) <<< FRAC_BITS;
      s3_next.den = DEN_S'(s2.b);
    end else begin
      s3_next.base = (-BASE_W'(s2.b)) <<< FRAC_BITS;
      s3_next.den = DEN_S'(s2.a) <<< 1;
    end
    s3_next.rad = (s3_next.kind == KIND_TWO) ?
                  (RAD_W'(d[D_W-2:0]) << (2 * FRAC_BITS)) : '0;
    s3_next.rem = '0;
    s3_next.root = '0;
  end

  for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_sqrt
    qrs_sqrt_cell u_cell (
      .clk   (clk),
      .rst   (rst),
      .en    (en),
      .prev  (sq[i]),
      .stage (sq[i+1])
    );
  end

  always_comb begin
    bx = NUM_S'(sq[SQRT_STEPS].base);
    sx = $signed({2'b00, sq[SQRT_STEPS].root});
    case (sq[SQRT_STEPS].kind)
      KIND_TWO: begin
        n1 = bx - sx;
        n2 = bx + sx;
      end
      KIND_DBL: begin
        n1 = bx;
        n2 = bx;
      end
      KIND_LIN: begin
        n1 = bx;
        n2 = '0;
      end
      default: begin
        n1 = '0;
        n2 = '0;
      end
    endcase
    m1 = n1[NUM_S-1] ? -n1 : n1;
    m2 = n2[NUM_S-1] ? -n2 : n2;
    dabs = sq[SQRT_STEPS].den[DEN_S-1] ? -sq[SQRT_STEPS].den : sq[SQRT_STEPS].den;
    dv_next.valid = sq[SQRT_STEPS].valid;
    dv_next.kind = sq[SQRT_STEPS].kind;
    dv_next.neg1 = n1[NUM_S-1] ^ sq[SQRT_STEPS].den[DEN_S-1];
    dv_next.neg2 = n2[NUM_S-1] ^ sq[SQRT_STEPS].den[DEN_S-1];
    dv_next.dmag = (dabs == '0) ? DMAG_W'(1) : dabs[DMAG_W-1:0];
    dv_next.l1.num = m1[NUM_W-1:0];
    dv_next.l1.rem = '0;
    dv_next.l1.q = '0;
    dv_next.l2.num = m2[NUM_W-1:0];
    dv_next.l2.rem = '0;
    dv_next.l2.q = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dv[0].valid <= 1'b0;
    end else if (en) begin
      dv[0] <= dv_next;
    end
  end

  for (genvar i = 0; i < NUM_W; i++) begin : g_div
    qrs_div_cell u_cell (
      .clk   (clk),
      .rst   (rst),
      .en    (en),
      .prev  (dv[i]),
      .stage (dv[i+1])
    );
  end

  always_comb begin
    q1 = ROOT_BITS'(dv[NUM_W].l1.q);
    q2 = ROOT_BITS'(dv[NUM_W].l2.q);
    if (dv[NUM_W].neg1) begin
      q1 = -q1;
    end
    if (dv[NUM_W].neg2) begin
      q2 = -q2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      roots.valid <= 1'b0;
    end else if (en) begin
      roots.valid <= dv[NUM_W].valid;
      case (dv[NUM_W].kind)
        KIND_TWO: begin
          roots.root_count <= CNT_TWO;
          roots.first_root <= q1;
          roots.second_root <= q2;
        end
        KIND_DBL: begin
          roots.root_count <= CNT_ONE;
          roots.first_root <= q1;
          roots.second_root <= q2;
        end
        KIND_LIN: begin
          roots.root_count <= CNT_ONE;
          roots.first_root <= q1;
          roots.second_root <= '0;
        end
        KIND_ALL: begin
          roots.root_count <= CNT_ALL;
          roots.first_root <= '0;
          roots.second_root <= '0;
        end
        default: begin
          roots.root_count <= CNT_NONE;
          roots.first_root <= '0;
          roots.second_root <= '0;
        end
      endcase
    end
  end

  a_absent_zero: assert property (@(posedge clk) disable iff (rst)
    roots.valid && (roots.root_count == CNT_NONE || roots.root_count == CNT_ALL)
    |-> roots.first_root == '0 && roots.second_root == '0)
    else $error("absent roots not zero");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !roots.valid)
    else $error("result valid after reset");

  a_div_remainder: assert property (@(posedge clk) disable iff (rst)
    dv[NUM_W].valid |-> dv[NUM_W].l1.rem < DREM_W'(dv[NUM_W].dmag))
    else $error("division remainder out of range");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    !en && sq[SQRT_STEPS].valid |=> sq[SQRT_STEPS].valid && $stable(sq[SQRT_STEPS].root))
    else $error("square root chain moved during stall");
endmodule

FILE: tb/sv/quadratic_root_solver_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Quadratic root solver testbench
// Drives coefficient words with random gaps and checks every root word
// against an in-bench solver of the same fixed-point arithmetic.
// ----------------------------------------------------------------------------
module quadratic_root_solver_test;
  import qrs_pkg::*;

  class root_scoreboard;
    logic [1:0]            cnt_q[$];
    logic [ROOT_BITS-1:0]  r1_q[$];
    logic [ROOT_BITS-1:0]  r2_q[$];
    int                    errors;
    int                    checked;

    function longint coef_to_int(logic [COEF_BITS-1:0] raw);
      return longint'(signed'(raw));
    endfunction

    function longint unsigned floor_sqrt(longint unsigned d);
      longint unsigned rem;
      longint unsigned rt;
      longint unsigned pair;
      longint unsigned trial;
      rem = 0;
      rt = 0;
      for (int k = SQRT_PAIRS + FRAC_BITS - 1; k >= 0; k--) begin
        pair = 0;
        if (k >= FRAC_BITS) pair = (d >> (2 * (k - FRAC_BITS))) & 3;
        rem = (rem << 2) | pair;
        trial = (rt << 2) | 1;
        if (rem >= trial) begin
          rem -= trial;
          rt = (rt << 1) | 1;
        end else begin
          rt = rt << 1;
        end
      end
      return rt;
    endfunction

    function logic [ROOT_BITS-1:0] clamp(longint v);
      longint hi;
      longint lo;
      hi = (longint'(1) << (ROOT_BITS - 1)) - 1;
      lo = -hi - 1;
      if (v > hi) v = hi;
      if (v < lo) v = lo;
      return v[ROOT_BITS-1:0];
    endfunction

    function void note_coefs(logic [COEF_BITS-1:0] ra, logic [COEF_BITS-1:0] rb,
                             logic [COEF_BITS-1:0] rc);
      longint a, b, c, one, d, den, s, r1, r2;
      logic [1:0] cnt;
      a = coef_to_int(ra);
      b = coef_to_int(rb);
      c = coef_to_int(rc);
      one = longint'(1) << FRAC_BITS;
      r1 = 0;
      r2 = 0;
      if (a == 0) begin
        if (b == 0) begin
          cnt = (c == 0) ? CNT_ALL : CNT_NONE;
        end else begin
          cnt = CNT_ONE;
          r1 = (-c * one) / b;
        end
      end else begin
        d = b * b - 4 * a * c;
        den = 2 * a;
        if (d < 0) begin
          cnt = CNT_NONE;
        end else if (d == 0) begin
          cnt = CNT_ONE;
          r1 = (-b * one) / den;
          r2 = r1;
        end else begin
          s = longint'(floor_sqrt(longint'(unsigned'(d))));
          cnt = CNT_TWO;
          r1 = (-b * one - s) / den;
          r2 = (-b * one + s) / den;
        end
      end
      cnt_q.push_back(cnt);
      r1_q.push_back(clamp(r1));
      r2_q.push_back(clamp(r2));
    endfunction

    function void check_roots(logic [1:0] cnt, logic [ROOT_BITS-1:0] r1,
                              logic [ROOT_BITS-1:0] r2);
      logic [1:0]           ec;
      logic [ROOT_BITS-1:0] e1, e2;
      checked++;
      if (cnt_q.size() == 0) begin
        $display("%0t: unexpected root word count=%0d", $time, cnt);
        errors++;
        return;
      end
      ec = cnt_q.pop_front();
      e1 = r1_q.pop_front();
      e2 = r2_q.pop_front();
      if (cnt !== ec) begin
        $display("%0t: root_count expected %0d actual %0d", $time, ec, cnt);
        errors++;
      end
      if (r1 !== e1) begin
        $display("%0t: first_root expected %h actual %h", $time, e1, r1);
        errors++;
      end
      if (r2 !== e2) begin
        $display("%0t: second_root expected %h actual %h", $time, e2, r2);
        errors++;
      end
    endfunction
  endclass

  localparam int RANDOM_WORDS = 930;
  localparam int WATCHDOG_LIMIT = 2000;

  logic clk;
  logic rst;
  int   idle_cycles = 0;
  int   sent;
  bit   timed_out;
  bit   stim_done;
  root_scoreboard sb;

  qrs_in_if  coefs ();
  qrs_out_if roots ();

  quadratic_root_solver dut (
    .clk   (clk),
    .rst   (rst),
    .coefs (coefs.sink),
    .roots (roots.source)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  task automatic send_word(logic [15:0] a, logic [15:0] b, logic [15:0] c);
    int gap;
    gap = $urandom_range(0, 6);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      coefs.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    coefs.valid  <= 1'b1;
    coefs.coef_a <= a;
    coefs.coef_b <= b;
    coefs.coef_c <= c;
    do @(posedge clk); while (!coefs.ready);
    sb.note_coefs(a, b, c);
    sent++;
  endtask

  function automatic logic [15:0] pick_coef();
    case ($urandom_range(0, 5))
      0: return 16'(signed'($urandom_range(0, 8)) - 4);
      1: return 16'h8000;
      2: return 16'h7fff;
      3: return 16'(signed'($urandom_range(0, 200)) - 100);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic drive_coefs();
    logic [15:0] a, r1, r2;
    send_word(16'sd0, 16'sd0, 16'sd0);
    send_word(16'sd0, 16'sd0, 16'sd5);
    send_word(16'sd0, 16'sd3, -16'sd7);
    send_word(16'sd0, -16'sd32768, 16'sd32767);
    send_word(16'sd1, -16'sd2, 16'sd1);
    send_word(-16'sd3, 16'sd12, -16'sd12);
    send_word(16'sd1, 16'sd0, 16'sd1);
    send_word(16'sd1, 16'sd0, -16'sd2);
    send_word(-16'sd1, 16'sd5, 16'sd3);
    send_word(-16'sd32768, -16'sd32768, 16'sd32767);
    send_word(16'sd32767, 16'sd32767, -16'sd32768);
    send_word(-16'sd32768, -16'sd32768, -16'sd32768);
    send_word(16'sd32767, 16'sd32767, 16'sd32767);
    send_word(16'sd1, -16'sd32768, -16'sd32768);
    send_word(16'sd1, 16'sd32767, 16'sd0);
    send_word(16'hffff, 16'hffff, 16'hffff);
    send_word(16'h5555, 16'haaaa, 16'h5555);
    send_word(16'haaaa, 16'h5555, 16'haaaa);
    for (int i = 0; i < RANDOM_WORDS; i++) begin
      case ($urandom_range(0, 4))
        0: begin
          r1 = 16'(signed'($urandom_range(0, 400)) - 200);
          r2 = 16'(signed'($urandom_range(0, 400)) - 200);
          a = 16'(signed'($urandom_range(1, 20)) * ($urandom_range(0, 1) ? 1 : -1));
          send_word(a, 16'(-(signed'(a) * (signed'(r1) + signed'(r2)))),
                    16'(signed'(a) * signed'(r1) * signed'(r2)));
        end
        1: send_word(16'sd0, pick_coef(), pick_coef());
        default: send_word(pick_coef(), pick_coef(), pick_coef());
      endcase
    end
  endtask

  initial begin
    sb = new();
    rst = 1'b1;
    sent = 0;
    stim_done = 0;
    coefs.valid <= 1'b0;
    coefs.coef_a <= '0;
    coefs.coef_b <= '0;
    coefs.coef_c <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    drive_coefs();
    coefs.valid <= 1'b0;
    stim_done = 1;
  end

  initial begin
    int stall;
    roots.ready <= 1'b0;
    wait (rst == 1'b0);
    forever begin
      stall = $urandom_range(0, 6);
      if ($urandom_range(0, 3) == 0) stall = 0;
      if (stall > 0) begin
        roots.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      roots.ready <= 1'b1;
      do @(posedge clk); while (!roots.valid);
      sb.check_roots(roots.root_count, roots.first_root, roots.second_root);
    end
  end

  always @(posedge clk) begin
    if (rst || (coefs.valid && coefs.ready) || (roots.valid && roots.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    timed_out = 0;
    wait (rst == 1'b0);
    while (!(stim_done && sb.cnt_q.size() == 0) && idle_cycles < WATCHDOG_LIMIT)
      @(posedge clk);
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      timed_out = 1;
    end else begin
      repeat (120) @(posedge clk);
    end
    $display("Sent %0d coefficient words, checked %0d root words.", sent, sb.checked);
    $display("Covered linear, double, two-root and no-root cases with random stalls.");
    if (!timed_out && sb.errors == 0 && sb.cnt_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

FILE: filelist.f
src/qrs_pkg.sv
src/qrs_in_if.sv
src/qrs_out_if.sv
src/qrs_sqrt_cell.sv
src/qrs_div_cell.sv
src/quadratic_root_solver.sv
tb/sv/quadratic_root_solver_test.sv
